FILE: hdl/magnetometer_calibrate_and_alarm_defines.svh
// Assertion macros for the magnetometer calibration block.
// The property is sampled on clk; rst comes from the enclosing module.
`ifndef MAGNETOMETER_CALIBRATE_AND_ALARM_DEFINES_SVH
`define MAGNETOMETER_CALIBRATE_AND_ALARM_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only outside reset.
`define MCA_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mca check failed");

// Checked on every edge, reset included.
`define MCA_CHECK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mca reset check failed");

`else

`define MCA_CHECK(label, prop)
`define MCA_CHECK_ALWAYS(label, prop)

`endif

`endif

FILE: hdl/mca_pkg.sv
package mca_pkg;

  localparam int SampleW = 20;
  localparam int DiffW   = 21;
  localparam int CoefW   = 16;
  localparam int ProdW   = 2 * DiffW;
  localparam int AccW    = 41;
  localparam int LevelW  = 19;
  localparam int ThrSqW  = 2 * LevelW;
  localparam int FracW   = 14;

  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1 << (FracW - 1));
  localparam logic signed [AccW-FracW-1:0] SatMax = (AccW-FracW)'(524287);
  localparam logic signed [AccW-FracW-1:0] SatMin = -(AccW-FracW)'(524288);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE,
    ST_HOLD
  } state_t;

  typedef enum logic [1:0] {
    ALARM_NONE = 2'd0,
    ALARM_MID  = 2'd1,
    ALARM_HIGH = 2'd2
  } alarm_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_OFFSETS    = 3'd0;
  localparam logic [2:0] REG_ROW_X      = 3'd1;
  localparam logic [2:0] REG_ROW_Y      = 3'd2;
  localparam logic [2:0] REG_ROW_Z      = 3'd3;
  localparam logic [2:0] REG_LEVEL_MID  = 3'd4;
  localparam logic [2:0] REG_LEVEL_HIGH = 3'd5;
  localparam logic [2:0] REG_SLOW       = 3'd6;
  localparam logic [2:0] REG_FAST       = 3'd7;

  // Operand groups walked by the shared multiplier.
  localparam logic [2:0] GRP_ROW_X  = 3'd0;
  localparam logic [2:0] GRP_ROW_Y  = 3'd1;
  localparam logic [2:0] GRP_ROW_Z  = 3'd2;
  localparam logic [2:0] GRP_SQUARE = 3'd3;
  localparam logic [2:0] GRP_THRESH = 3'd4;
  localparam logic [2:0] GRP_DONE   = 3'd5;

  // Round to nearest (ties up) from Q.14 and clamp to the sample range.
  function automatic logic signed [SampleW-1:0] round_sat(input logic signed [AccW-1:0] s);
    logic signed [AccW-1:0]       biased;
    logic signed [AccW-FracW-1:0] r;
    biased = s + RoundHalf;
    r = biased[AccW-1:FracW];
    if (r > SatMax) begin
      round_sat = SatMax[SampleW-1:0];
    end else if (r < SatMin) begin
      round_sat = SatMin[SampleW-1:0];
    end else begin
      round_sat = r[SampleW-1:0];
    end
  endfunction

endpackage

FILE: hdl/magnetometer_calibrate_and_alarm.sv
// One sample at a time: in_ready is high only in ST_IDLE, until the result has
// moved to the output register. One shared 21x21 signed multiplier is issued
// 14 times per item (9 matrix products, 3 squares, 2 squared thresholds).
// Configuration beats are taken on any cycle (cfg_ready is always high).
// Synchronous active-high reset: identity matrix, zero offsets, default levels
// and periods, LED and buzzer off, last toggle time zero, no result pending.
`include "magnetometer_calibrate_and_alarm_defines.svh"

module magnetometer_calibrate_and_alarm (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // sample channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [19:0] raw_x,
  input  logic signed [19:0] raw_y,
  input  logic signed [19:0] raw_z,
  input  logic        read_ok,
  input  logic [31:0] now_ms,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [19:0] cal_x,
  output logic signed [19:0] cal_y,
  output logic signed [19:0] cal_z,
  output logic [1:0]  alarm_level,
  output logic        led_on,
  output logic        buzzer_on
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [59:0] offsets;
  logic [47:0] mrow [3];
  logic [mca_pkg::LevelW-1:0] level_mid;
  logic [mca_pkg::LevelW-1:0] level_high;
  logic [15:0] period_slow;
  logic [15:0] period_fast;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offsets     <= '0;
      mrow[0]     <= 48'h0000_0000_4000;
      mrow[1]     <= 48'h0000_4000_0000;
      mrow[2]     <= 48'h4000_0000_0000;
      level_mid   <= 19'd3200;
      level_high  <= 19'd16000;
      period_slow <= 16'd500;
      period_fast <= 16'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mca_pkg::REG_OFFSETS:    offsets     <= cfg_data[59:0];
        mca_pkg::REG_ROW_X:      mrow[0]     <= cfg_data[47:0];
        mca_pkg::REG_ROW_Y:      mrow[1]     <= cfg_data[47:0];
        mca_pkg::REG_ROW_Z:      mrow[2]     <= cfg_data[47:0];
        mca_pkg::REG_LEVEL_MID:  level_mid   <= cfg_data[18:0];
        mca_pkg::REG_LEVEL_HIGH: level_high  <= cfg_data[18:0];
        mca_pkg::REG_SLOW:       period_slow <= cfg_data[15:0];
        mca_pkg::REG_FAST:       period_fast <= cfg_data[15:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  mca_pkg::state_t state, state_next;

  logic [2:0] grp;     // operand group being issued
  logic [1:0] col;     // column / axis within the group
  logic       pvalid;  // prod holds a product to fold in
  logic [2:0] pgrp;
  logic [1:0] pcol;

  logic in_beat;
  logic out_free;
  logic last_fold;

  assign in_ready  = (state == mca_pkg::ST_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign last_fold = pvalid && (pgrp == mca_pkg::GRP_THRESH) && (pcol == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mca_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mca_pkg::ST_IDLE:   if (in_valid) state_next = mca_pkg::ST_CALC;
      mca_pkg::ST_CALC:   if (last_fold) state_next = mca_pkg::ST_DECIDE;
      mca_pkg::ST_DECIDE: state_next = mca_pkg::ST_HOLD;
      mca_pkg::ST_HOLD:   if (out_free) state_next = mca_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sample capture: hard-iron subtraction happens on the input beat.
  // A failed read zeroes the difference, so the matrix yields a zero field.
  // ---------------------------------------------------------------------------
  logic signed [mca_pkg::DiffW-1:0] d [3];
  logic [31:0] now_q;

  always_ff @(posedge clk) begin
    if (in_beat) begin
      now_q <= now_ms;
      if (read_ok) begin
        d[0] <= {raw_x[19], raw_x} - {offsets[19], offsets[19:0]};
        d[1] <= {raw_y[19], raw_y} - {offsets[39], offsets[39:20]};
        d[2] <= {raw_z[19], raw_z} - {offsets[59], offsets[59:40]};
      end else begin
        d[0] <= '0;
        d[1] <= '0;
        d[2] <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: operand select, then a product register.
  // ---------------------------------------------------------------------------
  logic issue;
  logic [15:0] coef_w;
  logic signed [mca_pkg::DiffW-1:0] op_a, op_b;
  logic signed [mca_pkg::ProdW-1:0] prod;
  logic signed [mca_pkg::SampleW-1:0] c [3];

  assign issue = (state == mca_pkg::ST_CALC) && (grp != mca_pkg::GRP_DONE);

  always_comb begin
    coef_w = '0;
    op_a   = '0;
    op_b   = '0;
    unique case (col)
      2'd0:    coef_w = mrow[grp[1:0]][15:0];
      2'd1:    coef_w = mrow[grp[1:0]][31:16];
      default: coef_w = mrow[grp[1:0]][47:32];
    endcase
    unique case (grp)
      mca_pkg::GRP_ROW_X, mca_pkg::GRP_ROW_Y, mca_pkg::GRP_ROW_Z: begin
        op_a = d[col];
        op_b = {{(mca_pkg::DiffW - mca_pkg::CoefW){coef_w[15]}}, coef_w};
      end
      mca_pkg::GRP_SQUARE: begin
        op_a = {c[col][19], c[col]};
        op_b = {c[col][19], c[col]};
      end
      mca_pkg::GRP_THRESH: begin
        op_a = (col == 2'd0) ? {2'b00, level_high} : {2'b00, level_mid};
        op_b = op_a;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      grp <= mca_pkg::GRP_ROW_X;
      col <= 2'd0;
    end else if (issue) begin
      prod <= op_a * op_b;
      pgrp <= grp;
      pcol <= col;
      if (grp == mca_pkg::GRP_THRESH) begin
        if (col == 2'd1) begin
          grp <= mca_pkg::GRP_DONE;
        end else begin
          col <= col + 2'd1;
        end
      end else if (col == 2'd2) begin
        col <= 2'd0;
        grp <= grp + 3'd1;
      end else begin
        col <= col + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else begin
      pvalid <= issue;
    end
  end

  // ---------------------------------------------------------------------------
  // Accumulate: row and square groups sum three products each; matrix rows are
  // rounded and clamped into c, squares leave |c|^2 in acc; thresholds go to *_sq.
  // ---------------------------------------------------------------------------
  logic signed [mca_pkg::AccW-1:0] acc;
  logic signed [mca_pkg::AccW-1:0] acc_next;
  logic [mca_pkg::ThrSqW-1:0] high_sq, mid_sq;

  assign acc_next = ((pcol == 2'd0) ? '0 : acc) + prod[mca_pkg::AccW-1:0];

  always_ff @(posedge clk) begin
    if (pvalid) begin
      if (pgrp == mca_pkg::GRP_THRESH) begin
        if (pcol == 2'd0) begin
          high_sq <= prod[mca_pkg::ThrSqW-1:0];
        end else begin
          mid_sq <= prod[mca_pkg::ThrSqW-1:0];
        end
      end else begin
        acc <= acc_next;
        if (pgrp != mca_pkg::GRP_SQUARE && pcol == 2'd2) begin
          c[pgrp[1:0]] <= mca_pkg::round_sat(acc_next);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Alarm decision and LED / buzzer state
  // ---------------------------------------------------------------------------
  logic [39:0] mag_sq;
  logic [31:0] since;
  mca_pkg::alarm_t lvl_w, lvl;
  logic led_level, buzzer_level;
  logic [31:0] last_toggle;

  assign mag_sq = acc[39:0];
  assign since  = now_q - last_toggle;

  always_comb begin
    priority if (mag_sq > {2'b00, high_sq}) begin
      lvl_w = mca_pkg::ALARM_HIGH;
    end else if (mag_sq > {2'b00, mid_sq}) begin
      lvl_w = mca_pkg::ALARM_MID;
    end else begin
      lvl_w = mca_pkg::ALARM_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_level    <= 1'b0;
      buzzer_level <= 1'b0;
      last_toggle  <= '0;
    end else if (state == mca_pkg::ST_DECIDE) begin
      unique case (lvl_w)
        mca_pkg::ALARM_HIGH: begin
          led_level <= 1'b1;
          if (since >= {16'd0, period_fast}) begin
            last_toggle  <= now_q;
            buzzer_level <= ~buzzer_level;
          end
        end
        mca_pkg::ALARM_MID: begin
          buzzer_level <= 1'b0;
          if (since >= {16'd0, period_slow}) begin
            last_toggle <= now_q;
            led_level   <= ~led_level;
          end
        end
        default: begin
          led_level    <= 1'b0;
          buzzer_level <= 1'b0;
          last_toggle  <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == mca_pkg::ST_DECIDE) begin
      lvl <= lvl_w;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds the beat until taken; the core goes idle meanwhile.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mca_pkg::ST_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mca_pkg::ST_HOLD && out_free) begin
      cal_x       <= c[0];
      cal_y       <= c[1];
      cal_z       <= c[2];
      alarm_level <= lvl;
      led_on      <= led_level;
      buzzer_on   <= buzzer_level;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `MCA_CHECK(a_busy_after_beat, in_valid && in_ready |=> !in_ready)
  `MCA_CHECK(a_level_code, out_valid |-> alarm_level != 2'd3)
  `MCA_CHECK(a_high_led, out_valid && alarm_level == mca_pkg::ALARM_HIGH |-> led_on)
  `MCA_CHECK(a_quiet_none,
             out_valid && alarm_level == mca_pkg::ALARM_NONE |-> !led_on && !buzzer_on)
  `MCA_CHECK_ALWAYS(a_reset_clears, rst |=> !out_valid && in_ready)

endmodule
